// ===== src/assert_macros.svh =====
// ------------------------------------------------------------------
// assertion macros
// shared concurrent assertion wrappers for the rtl
// ------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define HCMM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hcmm assertion failed");

// next-cycle implication, checked outside reset
`define HCMM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hcmm assertion failed");

`endif

// ===== src/hcmm_pkg.sv =====
// ------------------------------------------------------------------
// hcmm_pkg
// constants and types of the handheld memory map decoder
// ------------------------------------------------------------------
package hcmm_pkg;

    localparam int VIDEO_DEPTH  = 8192;
    localparam int WORK_DEPTH   = 8192;
    localparam int SPRITE_DEPTH = 160;
    localparam int PORT_DEPTH   = 128;
    localparam int HIGH_DEPTH   = 127;

    localparam int VIDEO_AW  = $clog2(VIDEO_DEPTH);
    localparam int WORK_AW   = $clog2(WORK_DEPTH);
    localparam int SPRITE_AW = $clog2(SPRITE_DEPTH);
    localparam int PORT_AW   = $clog2(PORT_DEPTH);
    localparam int HIGH_AW   = $clog2(HIGH_DEPTH);

    // the clearing sweep covers the deepest store
    localparam int CLR_DEPTH = (VIDEO_DEPTH > WORK_DEPTH) ? VIDEO_DEPTH : WORK_DEPTH;
    localparam int CLR_AW    = $clog2(CLR_DEPTH);

    // address map boundaries (upper bounds exclusive)
    localparam logic [15:0] ADDR_BOOT_END   = 16'h0100;
    localparam logic [15:0] ADDR_VIDEO_BASE = 16'h8000;
    localparam logic [15:0] ADDR_EXT_BASE   = 16'hA000;
    localparam logic [15:0] ADDR_WORK_BASE  = 16'hC000;
    localparam logic [15:0] ADDR_SPRITE_BASE = 16'hFE00;
    localparam logic [15:0] ADDR_UNUSED_BASE = 16'hFEA0;
    localparam logic [15:0] ADDR_PORT_BASE  = 16'hFF00;
    localparam logic [15:0] ADDR_HIGH_BASE  = 16'hFF80;
    localparam logic [15:0] ADDR_IRQ_EN     = 16'hFFFF;

    // i/o port numbers
    localparam logic [PORT_AW-1:0] PORT_SERIAL_DATA = 7'h01;
    localparam logic [PORT_AW-1:0] PORT_SERIAL_CTRL = 7'h02;
    localparam logic [PORT_AW-1:0] PORT_BOOT_OFF    = 7'h50;

    // access kinds
    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    // route codes
    localparam logic [1:0] ROUTE_INTERNAL = 2'd0;
    localparam logic [1:0] ROUTE_BOOT     = 2'd1;
    localparam logic [1:0] ROUTE_CART     = 2'd2;
    localparam logic [1:0] ROUTE_IO       = 2'd3;

    // configuration register indexes
    localparam logic CFG_CLAIM_LOW  = 1'b0;
    localparam logic CFG_CLAIM_HIGH = 1'b1;

    // source of the read byte
    typedef enum logic [2:0] {
        SRC_NONE   = 3'd0,
        SRC_VIDEO  = 3'd1,
        SRC_WORK   = 3'd2,
        SRC_SPRITE = 3'd3,
        SRC_PORT   = 3'd4,
        SRC_HIGH   = 3'd5,
        SRC_IRQ    = 3'd6
    } t_src;

endpackage

// ===== src/handheld_console_memory_map_decoder.sv =====
// ------------------------------------------------------------------
// handheld_console_memory_map_decoder
// result path: store read, then result register
// throughput: 1 item per cycle unless stalled, set by each store's single access port
// reset: synchronous active low, then a clearing sweep of every store with o_ready low
// ------------------------------------------------------------------
`include "assert_macros.svh"

module handheld_console_memory_map_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // configuration write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [63:0] i_cfg_data,

    // access channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_mode,
    input  logic [15:0] i_bus_address,
    input  logic [7:0]  i_write_byte,
    input  logic        i_video_open,
    input  logic        i_sprite_open,

    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_read_byte,
    output logic [1:0]  o_route,
    output logic        o_serial_valid,
    output logic [7:0]  o_serial_byte,
    output logic        o_boot_active
);

    // ---------------------------------------------------------------
    // configuration: i/o claim masks
    // ---------------------------------------------------------------
    logic [63:0] r_mask_low;
    logic [63:0] r_mask_high;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask_low  <= '0;
            r_mask_high <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                hcmm_pkg::CFG_CLAIM_LOW:  r_mask_low  <= i_cfg_data;
                hcmm_pkg::CFG_CLAIM_HIGH: r_mask_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // clearing sweep after reset: zeroes every store one entry a cycle
    // ---------------------------------------------------------------
    logic [hcmm_pkg::CLR_AW-1:0] r_clr_idx;
    logic                        r_clr_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx  <= '0;
            r_clr_done <= 1'b0;
        end else if (!r_clr_done) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == hcmm_pkg::CLR_AW'(hcmm_pkg::CLR_DEPTH - 1)) begin
                r_clr_done <= 1'b1;
            end
        end
    end

    logic clr_sprite;
    logic clr_port;
    logic clr_high;

    assign clr_sprite = !r_clr_done &&
                        (r_clr_idx < hcmm_pkg::CLR_AW'(hcmm_pkg::SPRITE_DEPTH));
    assign clr_port   = !r_clr_done &&
                        (r_clr_idx < hcmm_pkg::CLR_AW'(hcmm_pkg::PORT_DEPTH));
    assign clr_high   = !r_clr_done &&
                        (r_clr_idx < hcmm_pkg::CLR_AW'(hcmm_pkg::HIGH_DEPTH));

    // ---------------------------------------------------------------
    // handshake: stage 1 holds the decoded access and store read data,
    // stage 2 is the result register
    // ---------------------------------------------------------------
    logic r_s1_valid;
    logic r_out_valid;
    logic s1_adv;
    logic in_acc;

    assign s1_adv  = !r_out_valid || i_ready;
    assign o_ready = r_clr_done && (!r_s1_valid || s1_adv);
    assign in_acc  = i_valid && o_ready;

    // small register state: boot overlay, interrupt enable, serial data shadow
    logic       r_boot;
    logic       n_boot;
    logic [7:0] r_irq;
    logic [7:0] r_serial_data;

    // ---------------------------------------------------------------
    // address decode, straight from the input ports at accept
    // ---------------------------------------------------------------
    logic       wr;
    logic [6:0] port_n;
    logic       port_claimed;
    logic       hit_video;
    logic       hit_work;
    logic       hit_sprite;
    logic       hit_port;
    logic       hit_high;
    logic       hit_irq;
    logic       dec_serial;
    logic       dec_boot_off;
    logic [1:0] dec_route;
    hcmm_pkg::t_src dec_src;

    assign wr           = (i_mode == hcmm_pkg::MODE_WRITE);
    assign port_n       = i_bus_address[6:0];
    // upper half of the port file uses the high mask
    assign port_claimed = port_n[6] ? r_mask_high[port_n[5:0]] : r_mask_low[port_n[5:0]];

    always_comb begin
        dec_route    = hcmm_pkg::ROUTE_INTERNAL;
        hit_video    = 1'b0;
        hit_work     = 1'b0;
        hit_sprite   = 1'b0;
        hit_port     = 1'b0;
        hit_high     = 1'b0;
        hit_irq      = 1'b0;
        dec_serial   = 1'b0;
        dec_boot_off = 1'b0;
        if (i_bus_address < hcmm_pkg::ADDR_VIDEO_BASE) begin
            // rom area: boot overlay on reads of the first page, cartridge otherwise
            if (!wr && r_boot && (i_bus_address < hcmm_pkg::ADDR_BOOT_END)) begin
                dec_route = hcmm_pkg::ROUTE_BOOT;
            end else begin
                dec_route = hcmm_pkg::ROUTE_CART;
            end
        end else if (i_bus_address < hcmm_pkg::ADDR_EXT_BASE) begin
            hit_video = i_video_open;
        end else if (i_bus_address < hcmm_pkg::ADDR_WORK_BASE) begin
            dec_route = hcmm_pkg::ROUTE_CART;
        end else if (i_bus_address < hcmm_pkg::ADDR_SPRITE_BASE) begin
            // work ram and its echo share the low 13 address bits
            hit_work = 1'b1;
        end else if (i_bus_address < hcmm_pkg::ADDR_UNUSED_BASE) begin
            hit_sprite = i_sprite_open;
        end else if (i_bus_address < hcmm_pkg::ADDR_PORT_BASE) begin
            // unusable area: nothing happens
        end else if (i_bus_address < hcmm_pkg::ADDR_HIGH_BASE) begin
            if (port_claimed) begin
                dec_route = hcmm_pkg::ROUTE_IO;
            end else begin
                hit_port     = 1'b1;
                dec_serial   = wr && (port_n == hcmm_pkg::PORT_SERIAL_CTRL);
                dec_boot_off = wr && (port_n == hcmm_pkg::PORT_BOOT_OFF) &&
                               (i_write_byte != 8'h00);
            end
        end else if (i_bus_address < hcmm_pkg::ADDR_IRQ_EN) begin
            hit_high = 1'b1;
        end else begin
            hit_irq = 1'b1;
        end
    end

    // read source only matters for reads
    always_comb begin
        dec_src = hcmm_pkg::SRC_NONE;
        if (!wr) begin
            if (hit_video) begin
                dec_src = hcmm_pkg::SRC_VIDEO;
            end else if (hit_work) begin
                dec_src = hcmm_pkg::SRC_WORK;
            end else if (hit_sprite) begin
                dec_src = hcmm_pkg::SRC_SPRITE;
            end else if (hit_port) begin
                dec_src = hcmm_pkg::SRC_PORT;
            end else if (hit_high) begin
                dec_src = hcmm_pkg::SRC_HIGH;
            end else if (hit_irq) begin
                dec_src = hcmm_pkg::SRC_IRQ;
            end
        end
    end

    // ---------------------------------------------------------------
    // small register state: boot overlay, interrupt enable, serial data shadow
    // ---------------------------------------------------------------
    assign n_boot = r_boot && !(in_acc && dec_boot_off);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_boot        <= 1'b1;
            r_irq         <= '0;
            r_serial_data <= '0;
        end else if (in_acc) begin
            r_boot <= n_boot;
            if (hit_irq && wr) begin
                r_irq <= i_write_byte;
            end
            // shadow of port 0x01 so serial capture needs no second read port
            if (hit_port && wr && (port_n == hcmm_pkg::PORT_SERIAL_DATA)) begin
                r_serial_data <= i_write_byte;
            end
        end
    end

    // ---------------------------------------------------------------
    // stores: one write or one registered read per cycle, cleared by the sweep
    // ---------------------------------------------------------------
    logic [7:0] video_mem  [hcmm_pkg::VIDEO_DEPTH];
    logic [7:0] work_mem   [hcmm_pkg::WORK_DEPTH];
    logic [7:0] sprite_mem [hcmm_pkg::SPRITE_DEPTH];
    logic [7:0] port_mem   [hcmm_pkg::PORT_DEPTH];
    logic [7:0] high_mem   [hcmm_pkg::HIGH_DEPTH];

    logic [7:0] r_video_q;
    logic [7:0] r_work_q;
    logic [7:0] r_sprite_q;
    logic [7:0] r_port_q;
    logic [7:0] r_high_q;

    logic [hcmm_pkg::VIDEO_AW-1:0]  video_addr;
    logic [hcmm_pkg::WORK_AW-1:0]   work_addr;
    logic [hcmm_pkg::SPRITE_AW-1:0] sprite_addr;
    logic [hcmm_pkg::PORT_AW-1:0]   port_addr;
    logic [hcmm_pkg::HIGH_AW-1:0]   high_addr;

    assign video_addr  = i_bus_address[hcmm_pkg::VIDEO_AW-1:0];
    assign work_addr   = i_bus_address[hcmm_pkg::WORK_AW-1:0];
    assign sprite_addr = i_bus_address[hcmm_pkg::SPRITE_AW-1:0];
    assign port_addr   = i_bus_address[hcmm_pkg::PORT_AW-1:0];
    assign high_addr   = i_bus_address[hcmm_pkg::HIGH_AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!r_clr_done) begin
            video_mem[r_clr_idx[hcmm_pkg::VIDEO_AW-1:0]] <= '0;
        end else if (in_acc && hit_video) begin
            if (wr) begin
                video_mem[video_addr] <= i_write_byte;
            end else begin
                r_video_q <= video_mem[video_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_clr_done) begin
            work_mem[r_clr_idx[hcmm_pkg::WORK_AW-1:0]] <= '0;
        end else if (in_acc && hit_work) begin
            if (wr) begin
                work_mem[work_addr] <= i_write_byte;
            end else begin
                r_work_q <= work_mem[work_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (clr_sprite) begin
            sprite_mem[r_clr_idx[hcmm_pkg::SPRITE_AW-1:0]] <= '0;
        end else if (in_acc && hit_sprite) begin
            if (wr) begin
                sprite_mem[sprite_addr] <= i_write_byte;
            end else begin
                r_sprite_q <= sprite_mem[sprite_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (clr_port) begin
            port_mem[r_clr_idx[hcmm_pkg::PORT_AW-1:0]] <= '0;
        end else if (in_acc && hit_port) begin
            if (wr) begin
                port_mem[port_addr] <= i_write_byte;
            end else begin
                r_port_q <= port_mem[port_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (clr_high) begin
            high_mem[r_clr_idx[hcmm_pkg::HIGH_AW-1:0]] <= '0;
        end else if (in_acc && hit_high) begin
            if (wr) begin
                high_mem[high_addr] <= i_write_byte;
            end else begin
                r_high_q <= high_mem[high_addr];
            end
        end
    end

    // ---------------------------------------------------------------
    // stage 1: decoded access waiting for its store read data
    // ---------------------------------------------------------------
    hcmm_pkg::t_src r_s1_src;
    logic [1:0]     r_s1_route;
    logic           r_s1_sv;
    logic [7:0]     r_s1_sb;
    logic           r_s1_boot;
    logic [7:0]     r_s1_irq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_src   <= dec_src;
            r_s1_route <= dec_route;
            r_s1_sv    <= dec_serial;
            // serial data as it stood before this write
            r_s1_sb    <= dec_serial ? r_serial_data : 8'h00;
            r_s1_boot  <= n_boot;
            r_s1_irq   <= r_irq;
        end
    end

    // ---------------------------------------------------------------
    // stage 2: result register
    // ---------------------------------------------------------------
    logic [7:0] n_read_byte;
    logic [7:0] r_out_read_byte;
    logic [1:0] r_out_route;
    logic       r_out_sv;
    logic [7:0] r_out_sb;
    logic       r_out_boot;

    always_comb begin
        case (r_s1_src)
            hcmm_pkg::SRC_VIDEO:  n_read_byte = r_video_q;
            hcmm_pkg::SRC_WORK:   n_read_byte = r_work_q;
            hcmm_pkg::SRC_SPRITE: n_read_byte = r_sprite_q;
            hcmm_pkg::SRC_PORT:   n_read_byte = r_port_q;
            hcmm_pkg::SRC_HIGH:   n_read_byte = r_high_q;
            hcmm_pkg::SRC_IRQ:    n_read_byte = r_s1_irq;
            default:              n_read_byte = 8'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_valid) begin
            r_out_read_byte <= n_read_byte;
            r_out_route     <= r_s1_route;
            r_out_sv        <= r_s1_sv;
            r_out_sb        <= r_s1_sb;
            r_out_boot      <= r_s1_boot;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_read_byte    = r_out_read_byte;
    assign o_route        = r_out_route;
    assign o_serial_valid = r_out_sv;
    assign o_serial_byte  = r_out_sb;
    assign o_boot_active  = r_out_boot;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    `HCMM_ASSERT_NOW(a_no_accept_while_clearing, i_clk, i_rst_n, !r_clr_done, !o_ready)
    `HCMM_ASSERT_NEXT(a_boot_stays_off, i_clk, i_rst_n, !r_boot, !r_boot)
    `HCMM_ASSERT_NOW(a_serial_is_internal, i_clk, i_rst_n, o_valid && o_serial_valid, o_route == hcmm_pkg::ROUTE_INTERNAL)
    `HCMM_ASSERT_NOW(a_serial_byte_zero, i_clk, i_rst_n, o_valid && !o_serial_valid, o_serial_byte == 8'h00)

endmodule

// ===== tb/tb_handheld_console_memory_map_decoder.sv =====
// ------------------------------------------------------------------
// tb_handheld_console_memory_map_decoder
// self-checking bench for the handheld memory map decoder: a directed
// walk over every region and boundary, then random bus traffic under
// several i/o claim masks, each result checked against a local model
// ------------------------------------------------------------------
module tb_handheld_console_memory_map_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    // run shape
    localparam int RAND_PHASES    = 6;
    localparam int ITEMS_PER_PHASE = 225;
    localparam int LONG_HOLD      = 300;   // receiver hold-off that backs up the pipe
    localparam int SETTLE         = 4;     // margin past the store read and the result register
    localparam logic [63:0] SERIAL_PORT_BITS =
        (64'd1 << hcmm_pkg::PORT_SERIAL_DATA) | (64'd1 << hcmm_pkg::PORT_SERIAL_CTRL);

    // short names for the directed table
    localparam logic       M_RD    = hcmm_pkg::MODE_READ;
    localparam logic       M_WR    = hcmm_pkg::MODE_WRITE;
    localparam logic [1:0] RT_INT  = hcmm_pkg::ROUTE_INTERNAL;
    localparam logic [1:0] RT_BOOT = hcmm_pkg::ROUTE_BOOT;
    localparam logic [1:0] RT_CART = hcmm_pkg::ROUTE_CART;
    localparam logic [1:0] RT_IO   = hcmm_pkg::ROUTE_IO;

    // one bus access as it crosses the input channel
    typedef struct packed {
        logic        mode;
        logic [15:0] addr;
        logic [7:0]  wdata;
        logic        vopen;
        logic        sopen;
    } bus_access_t;

    // one decoded result as it leaves the block
    typedef struct packed {
        logic [7:0] rdata;
        logic [1:0] route;
        logic       ser_valid;
        logic [7:0] ser_byte;
        logic       boot;
    } bus_result_t;

    // directed row: access, optional hand-written expectation, and a flag
    // that clears both claim masks before the row is offered
    typedef struct packed {
        logic        unclaim;
        logic        mode;
        logic [15:0] addr;
        logic [7:0]  wdata;
        logic        vopen;
        logic        sopen;
        logic        typed;
        logic [7:0]  rdata;
        logic [1:0]  route;
        logic        ser_valid;
        logic [7:0]  ser_byte;
        logic        boot;
    } dir_row_t;

    // what the monitor needs per offered item, in offer order
    typedef struct {
        bit          typed;
        bus_result_t want;
    } offer_note_t;

    // directed walk; masks at the start claim ports 0x00, 0x3F, 0x50 and 0x7F
    localparam int DIR_ROWS = 29;
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        // boot overlay reads, rom reads and a rom write
        '{1'b0, M_RD, 16'h0000, 8'h00, 1'b1, 1'b1, 1'b1, 8'h00, RT_BOOT, 1'b0, 8'h00, 1'b1},
        '{1'b0, M_RD, 16'h00FF, 8'h00, 1'b1, 1'b1, 1'b1, 8'h00, RT_BOOT, 1'b0, 8'h00, 1'b1},
        '{1'b0, M_RD, 16'h0100, 8'h00, 1'b1, 1'b1, 1'b1, 8'h00, RT_CART, 1'b0, 8'h00, 1'b1},
        '{1'b0, M_WR, 16'h0000, 8'hFF, 1'b1, 1'b1, 1'b1, 8'h00, RT_CART, 1'b0, 8'h00, 1'b1},
        // video ram, open and blocked
        '{1'b0, M_WR, 16'h8000, 8'hA5, 1'b1, 1'b1, 1'b1, 8'h00, RT_INT, 1'b0, 8'h00, 1'b1},
        '{1'b0, M_RD, 16'h8000, 8'h00, 1'b0, 1'b1, 1'b1, 8'h00, RT_INT, 1'b0, 8'h00, 1'b1},
        '{1'b0, M_RD, 16'h8000, 8'h00, 1'b1, 1'b1, 1'b0, 8'h00, RT_INT, 1'b0, 8'h00, 1'b0},
        '{1'b0, M_WR, 16'h9FFF, 8'h5A, 1'b0, 1'b1, 1'b1, 8'h00, RT_INT, 1'b0, 8'h00, 1'b1},
        '{1'b0, M_RD, 16'h9FFF, 8'h00, 1'b1, 1'b1, 1'b0, 8'h00, RT_INT, 1'b0, 8'h00, 1'b0},
        // work ram seen through its echo, both ends
        '{1'b0, M_WR, 16'hC000, 8'h3C, 1'b1, 1'b1, 1'b1, 8'h00, RT_INT, 1'b0, 8'h00, 1'b1},
        '{1'b0, M_RD, 16'hE000, 8'h00, 1'b1, 1'b1, 1'b0, 8'h00, RT_INT, 1'b0, 8'h00, 1'b0},
        '{1'b0, M_WR, 16'hFDFF, 8'hC3, 1'b1, 1'b1, 1'b1, 8'h00, RT_INT, 1'b0, 8'h00, 1'b1},
        '{1'b0, M_RD, 16'hDDFF, 8'h00, 1'b1, 1'b1, 1'b0, 8'h00, RT_INT, 1'b0, 8'h00, 1'b0},
        // sprite ram last entry, open and blocked, then the unusable hole
        '{1'b0, M_WR, 16'hFE9F, 8'h11, 1'b1, 1'b1, 1'b1, 8'h00, RT_INT, 1'b0, 8'h00, 1'b1},
        '{1'b0, M_RD, 16'hFE9F, 8'h00, 1'b1, 1'b0, 1'b1, 8'h00, RT_INT, 1'b0, 8'h00, 1'b1},
        '{1'b0, M_RD, 16'hFE9F, 8'h00, 1'b1, 1'b1, 1'b0, 8'h00, RT_INT, 1'b0, 8'h00, 1'b0},
        '{1'b0, M_WR, 16'hFEA0, 8'hEE, 1'b1, 1'b1, 1'b1, 8'h00, RT_INT, 1'b0, 8'h00, 1'b1},
        '{1'b0, M_RD, 16'hFEFF, 8'h00, 1'b1, 1'b1, 1'b1, 8'h00, RT_INT, 1'b0, 8'h00, 1'b1},
        // claimed ports go outward; the boot-off write must not land
        '{1'b0, M_WR, 16'hFF50, 8'h01, 1'b1, 1'b1, 1'b1, 8'h00, RT_IO, 1'b0, 8'h00, 1'b1},
        '{1'b0, M_RD, 16'hFF7F, 8'h00, 1'b1, 1'b1, 1'b1, 8'h00, RT_IO, 1'b0, 8'h00, 1'b1},
        // serial data then serial control captures the old data byte
        '{1'b0, M_WR, 16'hFF01, 8'h77, 1'b1, 1'b1, 1'b1, 8'h00, RT_INT, 1'b0, 8'h00, 1'b1},
        '{1'b0, M_WR, 16'hFF02, 8'h81, 1'b1, 1'b1, 1'b0, 8'h00, RT_INT, 1'b0, 8'h00, 1'b0},
        // high ram top entry and the interrupt enable byte
        '{1'b0, M_WR, 16'hFFFE, 8'h5C, 1'b1, 1'b1, 1'b1, 8'h00, RT_INT, 1'b0, 8'h00, 1'b1},
        '{1'b0, M_RD, 16'hFFFE, 8'h00, 1'b1, 1'b1, 1'b0, 8'h00, RT_INT, 1'b0, 8'h00, 1'b0},
        '{1'b0, M_WR, 16'hFFFF, 8'h80, 1'b1, 1'b1, 1'b1, 8'h00, RT_INT, 1'b0, 8'h00, 1'b1},
        '{1'b0, M_RD, 16'hFFFF, 8'h00, 1'b1, 1'b1, 1'b0, 8'h00, RT_INT, 1'b0, 8'h00, 1'b0},
        // unclaimed: zero keeps the overlay, nonzero drops it for good
        '{1'b1, M_WR, 16'hFF50, 8'h00, 1'b1, 1'b1, 1'b1, 8'h00, RT_INT, 1'b0, 8'h00, 1'b1},
        '{1'b0, M_WR, 16'hFF50, 8'h01, 1'b1, 1'b1, 1'b1, 8'h00, RT_INT, 1'b0, 8'h00, 1'b0},
        '{1'b0, M_RD, 16'h0000, 8'h00, 1'b1, 1'b1, 1'b1, 8'h00, RT_CART, 1'b0, 8'h00, 1'b0}
    };

    // clock, reset and dut ports; every input known from time zero
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic        i_cfg_index   = hcmm_pkg::CFG_CLAIM_LOW;
    logic [63:0] i_cfg_data    = '0;
    logic        i_valid       = 1'b0;
    logic        o_ready;
    logic        i_mode        = hcmm_pkg::MODE_READ;
    logic [15:0] i_bus_address = '0;
    logic [7:0]  i_write_byte  = '0;
    logic        i_video_open  = 1'b0;
    logic        i_sprite_open = 1'b0;
    logic        o_valid;
    logic        i_ready       = 1'b0;
    logic [7:0]  o_read_byte;
    logic [1:0]  o_route;
    logic        o_serial_valid;
    logic [7:0]  o_serial_byte;
    logic        o_boot_active;

    // model of the decoder state; 2-state arrays start at zero like the dut
    bit [7:0]  video_mem  [hcmm_pkg::VIDEO_DEPTH];
    bit [7:0]  work_mem   [hcmm_pkg::WORK_DEPTH];
    bit [7:0]  sprite_mem [hcmm_pkg::SPRITE_DEPTH];
    bit [7:0]  port_mem   [hcmm_pkg::PORT_DEPTH];
    bit [7:0]  high_mem   [hcmm_pkg::HIGH_DEPTH];
    bit [7:0]  irq_en_reg;
    bit        boot_on    = 1'b1;
    bit [63:0] claim_lo;
    bit [63:0] claim_hi;

    // scoreboard
    bus_result_t expected_results [$];
    offer_note_t offered_notes    [$];
    int          err_count   = 0;
    int          n_accepted  = 0;
    int          n_checked   = 0;
    int          n_serial    = 0;
    int          n_outward   = 0;
    int          n_boot_hits = 0;

    // traffic shaping shared by the sender and the receiver
    bit idle_on  = 1'b1;
    bit hold_req = 1'b0;

    handheld_console_memory_map_decoder u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_mode         (i_mode),
        .i_bus_address  (i_bus_address),
        .i_write_byte   (i_write_byte),
        .i_video_open   (i_video_open),
        .i_sprite_open  (i_sprite_open),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_read_byte    (o_read_byte),
        .o_route        (o_route),
        .o_serial_valid (o_serial_valid),
        .o_serial_byte  (o_serial_byte),
        .o_boot_active  (o_boot_active)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // append at the tail of the scoreboard queues
    function automatic void add_note(input offer_note_t note);
        offered_notes.insert(offered_notes.size(), note);
    endfunction

    function automatic void add_expected(input bus_result_t res);
        expected_results.insert(expected_results.size(), res);
    endfunction

    // decode one access against the model and update its state
    function automatic bus_result_t decode_access(input bus_access_t acc);
        bus_result_t res;
        logic [6:0]  port_n;
        bit          claimed;
        bit          wr;
        res    = '0;
        wr     = (acc.mode == hcmm_pkg::MODE_WRITE);
        port_n = acc.addr[6:0];
        if (acc.addr < hcmm_pkg::ADDR_VIDEO_BASE) begin
            // rom space: boot overlay only shadows reads
            if (!wr && boot_on && acc.addr < hcmm_pkg::ADDR_BOOT_END)
                res.route = hcmm_pkg::ROUTE_BOOT;
            else
                res.route = hcmm_pkg::ROUTE_CART;
        end else if (acc.addr < hcmm_pkg::ADDR_EXT_BASE) begin
            if (acc.vopen) begin
                if (wr) video_mem[acc.addr[12:0]] = acc.wdata;
                else    res.rdata = video_mem[acc.addr[12:0]];
            end
        end else if (acc.addr < hcmm_pkg::ADDR_WORK_BASE) begin
            res.route = hcmm_pkg::ROUTE_CART;
        end else if (acc.addr < hcmm_pkg::ADDR_SPRITE_BASE) begin
            // work ram and echo both fold onto the low 13 address bits
            if (wr) work_mem[acc.addr[12:0]] = acc.wdata;
            else    res.rdata = work_mem[acc.addr[12:0]];
        end else if (acc.addr < hcmm_pkg::ADDR_UNUSED_BASE) begin
            if (acc.sopen) begin
                if (wr) sprite_mem[acc.addr[7:0]] = acc.wdata;
                else    res.rdata = sprite_mem[acc.addr[7:0]];
            end
        end else if (acc.addr < hcmm_pkg::ADDR_PORT_BASE) begin
            // unusable hole: nothing happens
        end else if (acc.addr < hcmm_pkg::ADDR_HIGH_BASE) begin
            claimed = port_n[6] ? claim_hi[port_n[5:0]] : claim_lo[port_n[5:0]];
            if (claimed) begin
                res.route = hcmm_pkg::ROUTE_IO;
            end else if (wr) begin
                if (port_n == hcmm_pkg::PORT_SERIAL_CTRL) begin
                    res.ser_valid = 1'b1;
                    res.ser_byte  = port_mem[hcmm_pkg::PORT_SERIAL_DATA];
                end
                if (port_n == hcmm_pkg::PORT_BOOT_OFF && acc.wdata != 8'h00)
                    boot_on = 1'b0;
                port_mem[port_n] = acc.wdata;
            end else begin
                res.rdata = port_mem[port_n];
            end
        end else if (acc.addr < hcmm_pkg::ADDR_IRQ_EN) begin
            if (wr) high_mem[acc.addr[6:0]] = acc.wdata;
            else    res.rdata = high_mem[acc.addr[6:0]];
        end else begin
            if (wr) irq_en_reg = acc.wdata;
            else    res.rdata = irq_en_reg;
        end
        res.boot = boot_on;
        return res;
    endfunction

    // mostly a small window near the base so reads find earlier writes
    function automatic logic [15:0] pick_offset(input int span);
        if ($urandom_range(0, 3) == 0)
            return 16'($urandom_range(0, span - 1));
        return 16'($urandom_range(0, 15));
    endfunction

    // random access weighted toward the internal stores and the special ports
    function automatic bus_access_t random_access();
        bus_access_t acc;
        int          sel;
        sel       = $urandom_range(0, 99);
        acc.mode  = 1'($urandom_range(0, 1));
        acc.wdata = 8'($urandom_range(0, 255));
        acc.vopen = ($urandom_range(0, 4) != 0);
        acc.sopen = ($urandom_range(0, 4) != 0);
        if (sel < 5)
            acc.addr = 16'($urandom_range(0, 16'h00FF));
        else if (sel < 10)
            acc.addr = 16'($urandom_range(0, 16'h7FFF));
        else if (sel < 22)
            acc.addr = hcmm_pkg::ADDR_VIDEO_BASE + pick_offset(hcmm_pkg::VIDEO_DEPTH);
        else if (sel < 27)
            acc.addr = 16'($urandom_range(16'hA000, 16'hBFFF));
        else if (sel < 36)
            acc.addr = hcmm_pkg::ADDR_WORK_BASE + pick_offset(hcmm_pkg::WORK_DEPTH);
        else if (sel < 45)
            acc.addr = 16'hE000 + pick_offset(16'h1E00);   // echo
        else if (sel < 55)
            acc.addr = hcmm_pkg::ADDR_SPRITE_BASE + pick_offset(hcmm_pkg::SPRITE_DEPTH);
        else if (sel < 58)
            acc.addr = 16'($urandom_range(hcmm_pkg::ADDR_UNUSED_BASE, 16'hFEFF));
        else if (sel < 80) begin
            // half the port traffic on serial data, serial control, boot off
            if ($urandom_range(0, 1) == 0) begin
                case ($urandom_range(0, 2))
                    0: acc.addr = hcmm_pkg::ADDR_PORT_BASE +
                                  16'(hcmm_pkg::PORT_SERIAL_DATA);
                    1: acc.addr = hcmm_pkg::ADDR_PORT_BASE +
                                  16'(hcmm_pkg::PORT_SERIAL_CTRL);
                    default: acc.addr = hcmm_pkg::ADDR_PORT_BASE +
                                        16'(hcmm_pkg::PORT_BOOT_OFF);
                endcase
            end else begin
                acc.addr = hcmm_pkg::ADDR_PORT_BASE + pick_offset(hcmm_pkg::PORT_DEPTH);
            end
        end else if (sel < 92)
            acc.addr = hcmm_pkg::ADDR_HIGH_BASE + pick_offset(hcmm_pkg::HIGH_DEPTH);
        else if (sel < 96)
            acc.addr = hcmm_pkg::ADDR_IRQ_EN;
        else
            acc.addr = 16'($urandom_range(0, 16'hFFFF));
        return acc;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch at result %0d: %s", $realtime, n_checked, msg);
        err_count++;
    endtask

    // write both claim masks; only called with the block idle
    task automatic load_claim_masks(input logic [63:0] lo, input logic [63:0] hi);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= hcmm_pkg::CFG_CLAIM_LOW;
        i_cfg_data  <= lo;
        @(posedge i_clk);
        i_cfg_index <= hcmm_pkg::CFG_CLAIM_HIGH;
        i_cfg_data  <= hi;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        claim_lo = lo;
        claim_hi = hi;
    endtask

    // offer one item, optionally after a random gap, and hold it until taken
    task automatic offer_access(input bus_access_t acc, input bit typed,
                                input bus_result_t want);
        offer_note_t note;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        note.typed = typed;
        note.want  = want;
        add_note(note);
        i_valid       <= 1'b1;
        i_mode        <= acc.mode;
        i_bus_address <= acc.addr;
        i_write_byte  <= acc.wdata;
        i_video_open  <= acc.vopen;
        i_sprite_open <= acc.sopen;
        @(posedge i_clk);
        while (o_ready !== 1'b1) @(posedge i_clk);
    endtask

    // wait until every accepted item has produced its result
    task automatic wait_for_results();
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // receiver: random stall bursts, one long hold-off on request
    initial begin
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // monitor: predict on every accepted item, check every delivered result
    always @(posedge i_clk) begin : monitor
        bus_access_t acc;
        bus_result_t want;
        offer_note_t note;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                acc  = '{i_mode, i_bus_address, i_write_byte, i_video_open, i_sprite_open};
                want = decode_access(acc);
                note = offered_notes.pop_front();
                // hand-written rows override the model's answer
                if (note.typed) want = note.want;
                add_expected(want);
                n_accepted++;
            end
            if (o_valid && i_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with no access outstanding");
                end else begin
                    want = expected_results.pop_front();
                    if (o_read_byte !== want.rdata)
                        report_mismatch($sformatf("read_byte %02h, want %02h",
                                                  o_read_byte, want.rdata));
                    if (o_route !== want.route)
                        report_mismatch($sformatf("route %0d, want %0d", o_route, want.route));
                    if (o_serial_valid !== want.ser_valid)
                        report_mismatch($sformatf("serial_valid %0b, want %0b",
                                                  o_serial_valid, want.ser_valid));
                    if (o_serial_byte !== want.ser_byte)
                        report_mismatch($sformatf("serial_byte %02h, want %02h",
                                                  o_serial_byte, want.ser_byte));
                    if (o_boot_active !== want.boot)
                        report_mismatch($sformatf("boot_active %0b, want %0b",
                                                  o_boot_active, want.boot));
                    if (want.ser_valid)                     n_serial++;
                    if (want.route == hcmm_pkg::ROUTE_IO)   n_outward++;
                    if (want.route == hcmm_pkg::ROUTE_BOOT) n_boot_hits++;
                end
                n_checked++;
            end
        end
    end

    // main sequence
    initial begin
        bus_access_t acc;
        bus_result_t want;
        logic [63:0] lo;
        logic [63:0] hi;
        // hold reset, then the block runs its clearing sweep
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (o_ready !== 1'b1) @(posedge i_clk);

        // directed walk; starting masks claim ports 0x00, 0x3F, 0x50 and 0x7F
        load_claim_masks(64'h8000_0000_0000_0001, 64'h8000_0000_0001_0000);
        for (int r = 0; r < DIR_ROWS; r++) begin
            if (DIRECTED[r].unclaim) begin
                i_valid <= 1'b0;
                wait_for_results();
                load_claim_masks('0, '0);
            end
            acc  = '{DIRECTED[r].mode, DIRECTED[r].addr, DIRECTED[r].wdata,
                     DIRECTED[r].vopen, DIRECTED[r].sopen};
            want = '{DIRECTED[r].rdata, DIRECTED[r].route, DIRECTED[r].ser_valid,
                     DIRECTED[r].ser_byte, DIRECTED[r].boot};
            offer_access(acc, DIRECTED[r].typed, want);
        end

        // random phases, each under its own claim masks
        for (int p = 0; p < RAND_PHASES; p++) begin
            i_valid <= 1'b0;
            wait_for_results();
            case (p)
                0: begin lo = '1; hi = '1; end                  // every port outward
                1: begin lo = {$urandom, $urandom}; hi = {$urandom, $urandom}; end
                2: begin lo = '0; hi = '0; end                  // every port internal
                3: begin                                        // sparse claims
                    lo = {$urandom, $urandom} & {$urandom, $urandom};
                    hi = {$urandom, $urandom} & {$urandom, $urandom};
                end
                4: begin lo = '0; hi = '1; end
                default: begin                                  // serial pair kept internal
                    lo = {$urandom, $urandom} & ~SERIAL_PORT_BITS;
                    hi = {$urandom, $urandom};
                end
            endcase
            load_claim_masks(lo, hi);
            // back up the pipe once while the sender keeps pushing
            if (p == 1) hold_req = 1'b1;
            // last phase runs back to back on both sides
            if (p == RAND_PHASES - 1) idle_on = 1'b0;
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
                offer_access(random_access(), 1'b0, '0);
        end

        i_valid <= 1'b0;
        wait_for_results();
        if (offered_notes.size() != 0 || expected_results.size() != 0)
            report_mismatch("accesses left without a result");

        $display("covered %0d accesses, %0d results checked over %0d mask settings",
                 n_accepted, n_checked, RAND_PHASES + 2);
        $display("  %0d serial captures, %0d outward port accesses, %0d boot rom reads",
                 n_serial, n_outward, n_boot_hits);
        if (err_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // watchdog, several times the slowest legal run including the clearing sweep
    initial begin
        #2_000_000;
        $display("timeout with %0d results still expected", expected_results.size());
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/hcmm_pkg.sv
src/handheld_console_memory_map_decoder.sv
tb/tb_handheld_console_memory_map_decoder.sv
